/* rtl/core/three_level_priority_fifo_defines.svh */
// Assertion macros shared by the three-level priority queue RTL.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef THREE_LEVEL_PRIORITY_FIFO_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_FIFO_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TLPF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TLPF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/tlpf_pkg.sv */
// Shared types and constants for the three-level priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tlpf_pkg;

   localparam int PAYLOAD_W = 32;
   localparam int SERIAL_W  = 16;
   localparam int CLASS_W   = 2;
   localparam int STATUS_W  = 3;

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_SERVICE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED    = 3'd0,
      ST_BAD_CLASS = 3'd1,
      ST_FULL      = 3'd2,
      ST_SERVED    = 3'd3,
      ST_EMPTY     = 3'd4
   } rsp_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH,
      S_RESP
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           load_req;
      logic           push;
      logic           pop;
      logic           finish;
      logic           capture;
      rsp_status_type code;
   } ctrl_cmd_type;

   // Status from the datapath, valid for the request held in the datapath.
   typedef struct packed {
      logic is_service;
      logic class_bad;
      logic queue_full;
      logic any_waiting;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/core/three_level_priority_fifo.sv */
// Top level of the three-level strict-priority queue.
// Depends on tlpf_pkg, tlpf_ctrl and tlpf_dp.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// req_operation selects an arrival (which stamps the item with a wrapping
// 16-bit serial and appends it to the queue of req_priority_class) or a
// service request (which pops the head of the highest-priority non-empty
// queue). Every request gives exactly one result beat: rsp_strobe is high for
// one cycle while the rsp_ ports carry status, serial, payload and class.
// The receiver cannot stall; each beat is taken in the cycle it is shown.
// An arrival, a rejected arrival or an empty service goes from S_EXEC
// straight to S_RESP, which shows its beat; a successful service passes
// through S_FETCH between them, because the entry store has a registered
// read port. No new request is taken before the result beat of the last
// one has gone; busy stays high from the accepting edge until then.
// Reset empties all queues and clears the serial counter; the store itself
// is not cleared, since no entry is read before it is written.
`default_nettype none

module three_level_priority_fifo
   import tlpf_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int NUM_CLASSES = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_operation,
   input  wire logic [CLASS_W-1:0]   req_priority_class,
   input  wire logic [PAYLOAD_W-1:0] req_payload,
   output logic                      rsp_strobe,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [SERIAL_W-1:0]       rsp_serial_number,
   output logic [PAYLOAD_W-1:0]      rsp_served_payload,
   output logic [CLASS_W-1:0]        rsp_served_class
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   tlpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_strobe(rsp_strobe)
   );

   tlpf_dp #(
      .DEPTH      (DEPTH),
      .NUM_CLASSES(NUM_CLASSES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_priority_class(req_priority_class),
      .req_payload       (req_payload),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_serial_number (rsp_serial_number),
      .rsp_served_payload(rsp_served_payload),
      .rsp_served_class  (rsp_served_class)
   );

endmodule

`default_nettype wire

/* rtl/core/tlpf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the queue entry store.
`default_nettype none

module tlpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/tlpf_ctrl.sv */
// Sequencing state machine of the three-level priority queue.
// Depends on tlpf_pkg and the assertion macros; drives the datapath commands.
`default_nettype none
`include "three_level_priority_fifo_defines.svh"

module tlpf_ctrl
   import tlpf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type stat,
   output ctrl_cmd_type       cmd,
   output logic               busy,
   output logic               rsp_strobe
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.is_service && stat.any_waiting) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_RESP;
            end
         end
         S_FETCH: state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.code   = ST_QUEUED;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         S_EXEC: begin
            if (stat.is_service) begin
               if (stat.any_waiting) begin
                  cmd.pop = 1'b1;
               end else begin
                  cmd.finish = 1'b1;
                  cmd.code   = ST_EMPTY;
               end
            end else if (stat.class_bad) begin
               cmd.finish = 1'b1;
               cmd.code   = ST_BAD_CLASS;
            end else if (stat.queue_full) begin
               cmd.finish = 1'b1;
               cmd.code   = ST_FULL;
            end else begin
               cmd.push   = 1'b1;
               cmd.finish = 1'b1;
               cmd.code   = ST_QUEUED;
            end
         end
         S_FETCH: cmd.capture = 1'b1;
         S_RESP:  rsp_strobe  = 1'b1;
         default: busy        = 1'b1;
      endcase
   end

   // After a result beat the block is ready for the next request.
   `TLPF_ASSERT_NEXT(a_strobe_then_ready, rsp_strobe, !busy, "ready did not follow a result beat")

endmodule

`default_nettype wire

/* rtl/core/tlpf_dp.sv */
// Datapath of the three-level priority queue: request and result registers,
// per-class pointers and counts, serial counter and the entry store.
// Depends on tlpf_pkg, tlpf_ram and the assertion macros.
`default_nettype none
`include "three_level_priority_fifo_defines.svh"

module tlpf_dp
   import tlpf_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int NUM_CLASSES = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_operation,
   input  wire logic [CLASS_W-1:0]   req_priority_class,
   input  wire logic [PAYLOAD_W-1:0] req_payload,
   input  wire ctrl_cmd_type         cmd,
   output dp_status_type             stat,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [SERIAL_W-1:0]       rsp_serial_number,
   output logic [PAYLOAD_W-1:0]      rsp_served_payload,
   output logic [CLASS_W-1:0]        rsp_served_class
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CIDX_W  = $clog2(NUM_CLASSES);
   localparam int ENTRIES = NUM_CLASSES * DEPTH;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int ENTRY_W = SERIAL_W + PAYLOAD_W;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // Held request.
   logic                 op_ff,    op_in;
   logic [CLASS_W-1:0]   class_ff, class_in;
   logic [PAYLOAD_W-1:0] pay_ff,   pay_in;

   // Queue bookkeeping.
   logic [PTR_W-1:0]    head_ff [NUM_CLASSES];
   logic [PTR_W-1:0]    head_in [NUM_CLASSES];
   logic [PTR_W-1:0]    tail_ff [NUM_CLASSES];
   logic [PTR_W-1:0]    tail_in [NUM_CLASSES];
   logic [CNT_W-1:0]    occ_ff  [NUM_CLASSES];
   logic [CNT_W-1:0]    occ_in  [NUM_CLASSES];
   logic [SERIAL_W-1:0] serial_ff, serial_in;

   // Result registers.
   rsp_status_type       res_status_ff, res_status_in;
   logic [SERIAL_W-1:0]  res_serial_ff, res_serial_in;
   logic [PAYLOAD_W-1:0] res_pay_ff,    res_pay_in;
   logic [CLASS_W-1:0]   res_class_ff,  res_class_in;

   logic [CIDX_W-1:0]  arr_idx;
   logic [CNT_W-1:0]   arr_occ;
   logic [PTR_W-1:0]   arr_tail;
   logic               pop_found;
   logic [CIDX_W-1:0]  pop_idx;
   logic [PTR_W-1:0]   pop_head;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   assign arr_idx = CIDX_W'(class_ff);

   // Tail and count of the arrival's class; the bad-class check covers the
   // codes that name no queue.
   always_comb begin
      arr_occ  = '0;
      arr_tail = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (CIDX_W'(c) == arr_idx) begin
            arr_occ  = occ_ff[c];
            arr_tail = tail_ff[c];
         end
      end
   end

   // Priority encoder: the lowest-numbered non-empty class wins.
   always_comb begin
      pop_found = 1'b0;
      pop_idx   = '0;
      pop_head  = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (occ_ff[c] != '0) begin
            pop_found = 1'b1;
            pop_idx   = CIDX_W'(c);
            pop_head  = head_ff[c];
         end
      end
   end

   assign stat.is_service  = (op_ff == OP_SERVICE);
   assign stat.class_bad   = ({2'b00, class_ff} >= 4'(NUM_CLASSES));
   assign stat.queue_full  = (arr_occ == FULL_CNT);
   assign stat.any_waiting = pop_found;

   assign wr_addr = ADDR_W'(int'(arr_idx) * DEPTH + int'(arr_tail));
   assign rd_addr = ADDR_W'(int'(pop_idx) * DEPTH + int'(pop_head));

   always_comb begin
      op_in    = op_ff;
      class_in = class_ff;
      pay_in   = pay_ff;
      if (cmd.load_req) begin
         op_in    = req_operation;
         class_in = req_priority_class;
         pay_in   = req_payload;
      end
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      serial_in = serial_ff;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (cmd.push && (CIDX_W'(c) == arr_idx)) begin
            tail_in[c] = (arr_tail == LAST_PTR) ? '0 : arr_tail + 1'b1;
            occ_in[c]  = occ_ff[c] + 1'b1;
         end
         if (cmd.pop && (CIDX_W'(c) == pop_idx)) begin
            head_in[c] = (pop_head == LAST_PTR) ? '0 : pop_head + 1'b1;
            occ_in[c]  = occ_ff[c] - 1'b1;
         end
      end
      if (cmd.push) begin
         serial_in = serial_ff + 1'b1;
      end
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_serial_in = res_serial_ff;
      res_pay_in    = res_pay_ff;
      res_class_in  = res_class_ff;
      if (cmd.finish) begin
         res_status_in = cmd.code;
         res_serial_in = cmd.push ? serial_ff : '0;
         res_pay_in    = '0;
         res_class_in  = '0;
      end
      if (cmd.pop) begin
         res_class_in = CLASS_W'(pop_idx);
      end
      if (cmd.capture) begin
         res_status_in = ST_SERVED;
         res_serial_in = rd_data[ENTRY_W-1:PAYLOAD_W];
         res_pay_in    = rd_data[PAYLOAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
            occ_ff[c]  <= '0;
         end
         serial_ff <= '0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         serial_ff <= serial_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      class_ff      <= class_in;
      pay_ff        <= pay_in;
      res_status_ff <= res_status_in;
      res_serial_ff <= res_serial_in;
      res_pay_ff    <= res_pay_in;
      res_class_ff  <= res_class_in;
   end

   tlpf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(ENTRIES)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.push),
      .wr_addr(wr_addr),
      .wr_data({serial_ff, pay_ff}),
      .rd_en  (cmd.pop),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_status         = res_status_ff;
   assign rsp_serial_number  = res_serial_ff;
   assign rsp_served_payload = res_pay_ff;
   assign rsp_served_class   = res_class_ff;

   `TLPF_ASSERT_NOW(a_push_legal, cmd.push, !stat.class_bad && !stat.queue_full, "push to a bad or full queue")
   `TLPF_ASSERT_NOW(a_pop_nonempty, cmd.pop, stat.any_waiting, "pop with every queue empty")
   `TLPF_ASSERT_NOW(a_capture_after_pop, cmd.capture, $past(cmd.pop), "store data captured without a read")

endmodule

`default_nettype wire
